>>> rtl/core/bounded_list_with_position_delete_macros.svh
// Assertion macros shared by the list checker.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef BOUNDED_LIST_WITH_POSITION_DELETE_MACROS_SVH
`define BOUNDED_LIST_WITH_POSITION_DELETE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BLPD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/blpd_pkg.sv
// Shared types and constants for the bounded linked list block.
// No dependencies.
package blpd_pkg;

    localparam int CMD_W  = 2;
    localparam int ITEM_W = 32;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_FRONT = 2'd0,
        CMD_DELETE_FRONT = 2'd1,
        CMD_DELETE_BACK  = 2'd2,
        CMD_DELETE_POS   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [ITEM_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [ITEM_W-1:0] item;
        logic [LEN_W-1:0]         length;
    } res_t;

endpackage

>>> rtl/core/blpd_channels.sv
// Valid/ready channel interfaces for list requests and results.
// Depends on blpd_pkg.
interface blpd_req_if import blpd_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [ITEM_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, cmd, value, position, input ready);
    modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface blpd_rsp_if import blpd_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [ITEM_W-1:0] item;
    logic [LEN_W-1:0]         length;

    modport source (output valid, status, item, length, input ready);
    modport sink   (input valid, status, item, length, output ready);
endinterface

>>> rtl/core/blpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/blpd_ctrl.sv
// Command sequencer: walks and relinks nodes held in the value and link RAMs.
// Depends on blpd_pkg; drives two blpd_ram instances owned by the top level.
module blpd_ctrl import blpd_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  req_t                          req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output res_t                          res,
    output logic                          link_wr_en,
    output logic [$clog2(CAPACITY)-1:0]   link_wr_addr,
    output logic [2*$clog2(CAPACITY)-1:0] link_wr_data,
    output logic                          link_rd_en,
    output logic [$clog2(CAPACITY)-1:0]   link_rd_addr,
    input  logic [2*$clog2(CAPACITY)-1:0] link_rd_data,
    output logic                          val_wr_en,
    output logic [$clog2(CAPACITY)-1:0]   val_wr_addr,
    output logic [DATA_WIDTH-1:0]         val_wr_data,
    output logic                          val_rd_en,
    output logic [$clog2(CAPACITY)-1:0]   val_rd_addr,
    input  logic [DATA_WIDTH-1:0]         val_rd_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DECODE   = 15'b000000000000010,
        S_INS_FREE = 15'b000000000000100,
        S_INS_WR   = 15'b000000000001000,
        S_INS_HWR  = 15'b000000000010000,
        S_INS_TRD  = 15'b000000000100000,
        S_INS_TWR  = 15'b000000001000000,
        S_WALK     = 15'b000000010000000,
        S_DEL_LOAD = 15'b000000100000000,
        S_DEL_PWR  = 15'b000001000000000,
        S_DEL_QRD  = 15'b000010000000000,
        S_DEL_QWR  = 15'b000100000000000,
        S_RELEASE  = 15'b001000000000000,
        S_DONE     = 15'b010000000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [IW-1:0]            head_reg, head_next;
    logic [IW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            used_reg, used_next;
    logic [IW-1:0]            free_head_reg, free_head_next;

    logic [IW-1:0]            cur_reg, cur_next;
    logic [IW-1:0]            p_reg, p_next;
    logic [IW-1:0]            q_reg, q_next;
    logic [POS_W-1:0]         steps_reg, steps_next;
    cmd_t                     cmd_reg, cmd_next;
    logic signed [ITEM_W-1:0] value_reg, value_next;
    status_t                  status_reg, status_next;
    logic [ITEM_W-1:0]        item_reg, item_next;

    logic [IW-1:0]            lk_next;
    logic [IW-1:0]            lk_prev;
    logic [DATA_WIDTH+ITEM_W-1:0] in_ext;
    logic [DATA_WIDTH-1:0]    store_data;
    logic [DATA_WIDTH-1:0]    item_src;
    logic [DATA_WIDTH+ITEM_W-1:0] item_ext;
    logic [ITEM_W-1:0]        item_conv;
    logic [CW+POS_W-1:0]      pos_ext;
    logic [CW+POS_W-1:0]      cnt_ext;
    logic [CW+LEN_W-1:0]      len_ext;

    // link word = {next, prev}
    assign lk_next = link_rd_data[2*IW-1:IW];
    assign lk_prev = link_rd_data[IW-1:0];

    assign in_ext     = {{DATA_WIDTH{value_reg[ITEM_W-1]}}, value_reg};
    assign store_data = in_ext[DATA_WIDTH-1:0];
    assign item_src   = (state_reg == S_INS_WR) ? store_data : val_rd_data;
    assign item_ext   = {{ITEM_W{item_src[DATA_WIDTH-1]}}, item_src};
    assign item_conv  = item_ext[ITEM_W-1:0];

    assign pos_ext = {{CW{1'b0}}, steps_reg};
    assign cnt_ext = {{POS_W{1'b0}}, count_reg};
    assign len_ext = {{LEN_W{1'b0}}, count_reg};

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.item   = item_reg;
    assign res.length = len_ext[LEN_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        steps_next     = steps_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        item_next      = item_reg;

        link_wr_en   = 1'b0;
        link_wr_addr = '0;
        link_wr_data = '0;
        link_rd_en   = 1'b0;
        link_rd_addr = '0;
        val_wr_en    = 1'b0;
        val_wr_addr  = '0;
        val_wr_data  = '0;
        val_rd_en    = 1'b0;
        val_rd_addr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    value_next = req.value;
                    steps_next = req.position;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = ST_OK;
                item_next   = '0;
                if (cmd_reg == CMD_INSERT_FRONT)
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (used_reg != CW'(CAPACITY))
                    begin
                        // never-used nodes first
                        cur_next   = used_reg[IW-1:0];
                        used_next  = used_reg + CW'(1);
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        link_rd_en   = 1'b1;
                        link_rd_addr = free_head_reg;
                        state_next   = S_INS_FREE;
                    end
                end
                else if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else if (cmd_reg == CMD_DELETE_FRONT || cmd_reg == CMD_DELETE_BACK)
                begin
                    cur_next     = (cmd_reg == CMD_DELETE_FRONT) ? head_reg : tail_reg;
                    link_rd_en   = 1'b1;
                    link_rd_addr = cur_next;
                    val_rd_en    = 1'b1;
                    val_rd_addr  = cur_next;
                    state_next   = S_DEL_LOAD;
                end
                else if (steps_reg == '0 || pos_ext > cnt_ext)
                begin
                    status_next = ST_BADPOS;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next     = head_reg;
                    link_rd_en   = 1'b1;
                    link_rd_addr = head_reg;
                    val_rd_en    = 1'b1;
                    val_rd_addr  = head_reg;
                    steps_next   = steps_reg - POS_W'(1);
                    state_next   = (steps_reg == POS_W'(1)) ? S_DEL_LOAD : S_WALK;
                end
            end

            S_WALK:
            begin
                // one link hop per cycle, read address taken from the RAM output
                cur_next     = lk_next;
                link_rd_en   = 1'b1;
                link_rd_addr = lk_next;
                val_rd_en    = 1'b1;
                val_rd_addr  = lk_next;
                steps_next   = steps_reg - POS_W'(1);
                if (steps_reg == POS_W'(1))
                begin
                    state_next = S_DEL_LOAD;
                end
            end

            S_DEL_LOAD:
            begin
                item_next = item_conv;
                p_next    = lk_prev;
                q_next    = lk_next;
                if (count_reg == CW'(1))
                begin
                    link_wr_en     = 1'b1;
                    link_wr_addr   = cur_reg;
                    link_wr_data   = {free_head_reg, cur_reg};
                    free_head_next = cur_reg;
                    head_next      = '0;
                    tail_next      = '0;
                    count_next     = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    link_rd_en   = 1'b1;
                    link_rd_addr = lk_prev;
                    state_next   = S_DEL_PWR;
                end
            end

            S_DEL_PWR:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = p_reg;
                link_wr_data = {q_reg, lk_prev};
                state_next   = S_DEL_QRD;
            end

            S_DEL_QRD:
            begin
                // read after the p write so that p == q sees the new word
                link_rd_en   = 1'b1;
                link_rd_addr = q_reg;
                state_next   = S_DEL_QWR;
            end

            S_DEL_QWR:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = q_reg;
                link_wr_data = {lk_next, p_reg};
                state_next   = S_RELEASE;
            end

            S_RELEASE:
            begin
                link_wr_en     = 1'b1;
                link_wr_addr   = cur_reg;
                link_wr_data   = {free_head_reg, cur_reg};
                free_head_next = cur_reg;
                if (cur_reg == head_reg)
                begin
                    head_next = q_reg;
                end
                if (cur_reg == tail_reg)
                begin
                    tail_next = p_reg;
                end
                count_next = count_reg - CW'(1);
                state_next = S_DONE;
            end

            S_INS_FREE:
            begin
                cur_next       = free_head_reg;
                free_head_next = lk_next;
                state_next     = S_INS_WR;
            end

            S_INS_WR:
            begin
                val_wr_en    = 1'b1;
                val_wr_addr  = cur_reg;
                val_wr_data  = store_data;
                item_next    = item_conv;
                link_wr_en   = 1'b1;
                link_wr_addr = cur_reg;
                if (count_reg == '0)
                begin
                    link_wr_data = {cur_reg, cur_reg};
                    head_next    = cur_reg;
                    tail_next    = cur_reg;
                    count_next   = CW'(1);
                    state_next   = S_DONE;
                end
                else
                begin
                    link_wr_data = {head_reg, tail_reg};
                    link_rd_en   = 1'b1;
                    link_rd_addr = head_reg;
                    state_next   = S_INS_HWR;
                end
            end

            S_INS_HWR:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = head_reg;
                link_wr_data = {lk_next, cur_reg};
                state_next   = S_INS_TRD;
            end

            S_INS_TRD:
            begin
                link_rd_en   = 1'b1;
                link_rd_addr = tail_reg;
                state_next   = S_INS_TWR;
            end

            S_INS_TWR:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = tail_reg;
                link_wr_data = {cur_reg, lk_prev};
                head_next    = cur_reg;
                count_next   = count_reg + CW'(1);
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            free_head_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            free_head_reg <= free_head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        steps_reg  <= steps_next;
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        item_reg   <= item_next;
    end

endmodule

>>> rtl/core/bounded_list_with_position_delete.sv
// Top level of the bounded doubly linked list: node RAMs, sequencer, result register.
// Depends on blpd_pkg, blpd_channels, blpd_ram and blpd_ctrl.
//
//  channel | dir | payload                          | transfer taken when
//  --------+-----+----------------------------------+----------------------
//  req     | in  | cmd[1:0], value[31:0], position  | req.valid && req.ready
//  rsp     | out | status[1:0], item[31:0], length  | rsp.valid && rsp.ready
//
//  One request at a time. A rejected request goes straight to the result. An
//  insert takes a never-used node or one from the free chain, writes it and,
//  unless the list was empty, relinks the old head and tail. A delete reads
//  the node, relinks its neighbours unless it empties the list, and frees the
//  node; a position delete first walks, one link RAM read per hop.
//  Reset clears head, tail, length and the allocator; node RAMs are not cleared.
//  The result register frees the sequencer, so the next request is taken while
//  a result still waits on rsp; a stalled rsp stalls req only once a second
//  result is ready.
module bounded_list_with_position_delete import blpd_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    blpd_req_if.sink   req,
    blpd_rsp_if.source rsp
);

    localparam int IW = $clog2(CAPACITY);

    req_t req_s;
    res_t res_s;
    logic res_valid;
    logic res_ready;

    // Node link RAM: one word per node, {next, prev}. Free nodes are chained
    // through their next field.
    logic            link_wr_en;
    logic [IW-1:0]   link_wr_addr;
    logic [2*IW-1:0] link_wr_data;
    logic            link_rd_en;
    logic [IW-1:0]   link_rd_addr;
    logic [2*IW-1:0] link_rd_data;

    // Node value RAM.
    logic                  val_wr_en;
    logic [IW-1:0]         val_wr_addr;
    logic [DATA_WIDTH-1:0] val_wr_data;
    logic                  val_rd_en;
    logic [IW-1:0]         val_rd_addr;
    logic [DATA_WIDTH-1:0] val_rd_data;

    // Result register between the sequencer and rsp.
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    assign req_s.cmd      = cmd_t'(req.cmd);
    assign req_s.value    = req.value;
    assign req_s.position = req.position;

    blpd_ram #(
        .WIDTH (2 * IW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    blpd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data),
        .rd_en   (val_rd_en),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    blpd_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_ready    (req.ready),
        .req          (req_s),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res_s),
        .link_wr_en   (link_wr_en),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data),
        .link_rd_en   (link_rd_en),
        .link_rd_addr (link_rd_addr),
        .link_rd_data (link_rd_data),
        .val_wr_en    (val_wr_en),
        .val_wr_addr  (val_wr_addr),
        .val_wr_data  (val_wr_data),
        .val_rd_en    (val_rd_en),
        .val_rd_addr  (val_rd_addr),
        .val_rd_data  (val_rd_data)
    );

    // The register takes a new result when empty or being drained this cycle.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_reg.status;
    assign rsp.item   = out_reg.item;
    assign rsp.length = out_reg.length;

endmodule

>>> rtl/core/blpd_checker.sv
// Port-level checker for the bounded linked list, bound to the top level.
// Depends on blpd_pkg and bounded_list_with_position_delete_macros.svh.
`include "bounded_list_with_position_delete_macros.svh"

module blpd_checker import blpd_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [1:0]        rsp_status,
    input logic [ITEM_W-1:0] rsp_item,
    input logic [LEN_W-1:0]  rsp_length
);

    logic             req_acc;
    logic             rsp_acc;
    logic [1:0]       pending_reg, pending_next;
    logic [LEN_W-1:0] last_len_reg, last_len_next;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next  = pending_reg;
        last_len_next = last_len_reg;
        if (req_acc && !rsp_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!req_acc && rsp_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
        if (rsp_acc)
        begin
            last_len_next = rsp_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            last_len_reg <= '0;
        end
        else
        begin
            pending_reg  <= pending_next;
            last_len_reg <= last_len_next;
        end
    end

    `BLPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_item) && $stable(rsp_length), "rsp dropped or changed while stalled")
    `BLPD_ASSERT_IMPLY(a_rsp_has_req, rsp_valid, pending_reg != 2'd0, "result without an open request")
    `BLPD_ASSERT_IMPLY(a_req_bound, req_acc, pending_reg != 2'd2, "request taken with two results open")
    `BLPD_ASSERT_IMPLY(a_reject_clean, rsp_valid && rsp_status != ST_OK, rsp_item == '0 && rsp_length == last_len_reg, "rejected request changed length or item")
    `BLPD_ASSERT_IMPLY(a_len_step, rsp_valid && rsp_status == ST_OK, rsp_length == LEN_W'(last_len_reg + LEN_W'(1)) || rsp_length == LEN_W'(last_len_reg - LEN_W'(1)), "length moved by other than one")

endmodule

bind bounded_list_with_position_delete blpd_checker u_blpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_item   (rsp.item),
    .rsp_length (rsp.length)
);

>>> bench/list_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bounded linked list: mirrors the node memory, links and free pool.
// Depends on blpd_pkg; connected to the request and result channel signals.
module list_checker import blpd_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic                     req_ready,
    input  logic [CMD_W-1:0]         req_cmd,
    input  logic signed [ITEM_W-1:0] req_value,
    input  logic [POS_W-1:0]         req_position,
    input  logic                     rsp_valid,
    input  logic                     rsp_ready,
    input  logic [1:0]               rsp_status,
    input  logic signed [ITEM_W-1:0] rsp_item,
    input  logic [LEN_W-1:0]         rsp_length,
    output int                       errors,
    output int                       pending,
    output int                       results_checked
);

    localparam int IDX_W = $clog2(CAPACITY);

    // mirrored list state
    logic signed [ITEM_W-1:0] node_data [CAPACITY];
    logic [IDX_W-1:0]         link_next [CAPACITY];
    logic [IDX_W-1:0]         link_prev [CAPACITY];
    logic [IDX_W-1:0]         head_node;
    logic [IDX_W-1:0]         tail_node;
    int unsigned              list_len;
    logic [IDX_W-1:0]         free_pool [CAPACITY];
    int unsigned              free_depth;

    res_t expected_results [$];

    function automatic void clear_list();
        for (int i = 0; i < CAPACITY; i++)
        begin
            free_pool[i] = IDX_W'(i);
        end
        free_depth = CAPACITY;
        head_node  = '0;
        tail_node  = '0;
        list_len   = 0;
    endfunction

    // unlink node n, return its value and give the node back to the pool
    function automatic logic signed [ITEM_W-1:0] take_node(input logic [IDX_W-1:0] n);
        logic [IDX_W-1:0]         p;
        logic [IDX_W-1:0]         q;
        logic signed [ITEM_W-1:0] v;
        v = node_data[n];
        if (list_len <= 1)
        begin
            head_node = '0;
            tail_node = '0;
            list_len  = 0;
        end
        else
        begin
            p = link_prev[n];
            q = link_next[n];
            link_next[p] = q;
            link_prev[q] = p;
            if (n == head_node)
                head_node = q;
            if (n == tail_node)
                tail_node = p;
            list_len--;
        end
        if (free_depth < CAPACITY)
        begin
            free_pool[free_depth] = n;
            free_depth++;
        end
        return v;
    endfunction

    function automatic res_t apply_command(input cmd_t c,
                                           input logic signed [ITEM_W-1:0] v,
                                           input logic [POS_W-1:0] pos);
        res_t             r;
        logic [IDX_W-1:0] n;
        r.status = ST_OK;
        r.item   = '0;
        if (c == CMD_INSERT_FRONT)
        begin
            if (list_len >= CAPACITY || free_depth == 0)
                r.status = ST_FULL;
            else
            begin
                free_depth--;
                n = free_pool[free_depth];
                node_data[n] = v;
                if (list_len == 0)
                begin
                    link_next[n] = n;
                    link_prev[n] = n;
                    tail_node    = n;
                end
                else
                begin
                    link_next[n]         = head_node;
                    link_prev[n]         = tail_node;
                    link_prev[head_node] = n;
                    link_next[tail_node] = n;
                end
                head_node = n;
                list_len++;
                r.item = v;
            end
        end
        else if (list_len == 0)
            r.status = ST_EMPTY;
        else if (c == CMD_DELETE_FRONT)
            r.item = take_node(head_node);
        else if (c == CMD_DELETE_BACK)
            r.item = take_node(tail_node);
        else if (pos == 0 || pos > list_len)
            r.status = ST_BADPOS;
        else
        begin
            n = head_node;
            for (int k = 1; k < pos; k++)
            begin
                n = link_next[n];
            end
            r.item = take_node(n);
        end
        r.length = LEN_W'(list_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t want;
        if (!rst_n)
        begin
            clear_list();
            expected_results.delete();
            errors          <= 0;
            pending         <= 0;
            results_checked <= 0;
        end
        else
        begin
            // a result can only belong to a request accepted at an earlier edge
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors <= errors + 1;
                    $error("result with no request outstanding: status %0d item %0d length %0d",
                           rsp_status, rsp_item, rsp_length);
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked <= results_checked + 1;
                    if (rsp_status !== want.status || rsp_item !== want.item
                        || rsp_length !== want.length)
                        errors <= errors + 1;
                    if (rsp_status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, rsp_status);
                    if (rsp_item !== want.item)
                        $error("item: expected %0d, got %0d", want.item, rsp_item);
                    if (rsp_length !== want.length)
                        $error("length: expected %0d, got %0d", want.length, rsp_length);
                end
            end
            if (req_valid && req_ready)
                expected_results.push_back(apply_command(cmd_t'(req_cmd), req_value,
                                                         req_position));
            pending <= expected_results.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Top of the list bench: clock, reset, request stimulus, result back-pressure, verdict.
// Depends on blpd_pkg, blpd_channels, list_checker and the list block itself.
module testbench;
    import blpd_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int WATCHDOG_LIMIT = 4000;
    // settle time at the end, scaled with CAPACITY, to watch for stray results
    localparam int DRAIN_CYCLES   = 4 * (7 + CAPACITY);

    logic clk;
    logic rst_n = 1'b0;

    // request drive, held in local flops so every input is known from time zero
    logic                     req_valid    = 1'b0;
    logic [CMD_W-1:0]         req_cmd      = '0;
    logic signed [ITEM_W-1:0] req_value    = '0;
    logic [POS_W-1:0]         req_position = '0;
    logic                     rsp_ready    = 1'b0;

    int errors;
    int pending;
    int results_checked;

    blpd_req_if req_bus ();
    blpd_rsp_if rsp_bus ();

    assign req_bus.valid    = req_valid;
    assign req_bus.cmd      = req_cmd;
    assign req_bus.value    = req_value;
    assign req_bus.position = req_position;
    assign rsp_bus.ready    = rsp_ready;

    bounded_list_with_position_delete #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (32)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    list_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_bus.valid),
        .req_ready       (req_bus.ready),
        .req_cmd         (req_bus.cmd),
        .req_value       (req_bus.value),
        .req_position    (req_bus.position),
        .rsp_valid       (rsp_bus.valid),
        .rsp_ready       (rsp_bus.ready),
        .rsp_status      (rsp_bus.status),
        .rsp_item        (rsp_bus.item),
        .rsp_length      (rsp_bus.length),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Result back-pressure. The receiver switches between styles every
    // so often: wide open, coin flip, long stalls with short open windows,
    // and mostly-open with short blips. Independent of the sender, so
    // stalls fall at any point relative to the request traffic.
    // ------------------------------------------------------------------
    int stall_mode;
    int stall_mode_left;
    int stall_hold;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready       <= 1'b0;
            stall_mode      <= 0;
            stall_mode_left <= 0;
            stall_hold      <= 0;
        end
        else
        begin
            if (stall_mode_left == 0)
            begin
                stall_mode      <= $urandom_range(0, 3);
                stall_mode_left <= $urandom_range(30, 300);
            end
            else
                stall_mode_left <= stall_mode_left - 1;

            if (stall_hold != 0)
                stall_hold <= stall_hold - 1;
            else
            begin
                case (stall_mode)
                    0:
                    begin
                        rsp_ready  <= 1'b1;
                        stall_hold <= 15;
                    end
                    1:
                    begin
                        rsp_ready  <= 1'($urandom_range(0, 1));
                        stall_hold <= 0;
                    end
                    2:
                    begin
                        // going low holds long, going high opens briefly
                        rsp_ready  <= ~rsp_ready;
                        stall_hold <= rsp_ready ? $urandom_range(0, 30) : $urandom_range(0, 4);
                    end
                    default:
                    begin
                        rsp_ready  <= ($urandom_range(0, 3) != 0);
                        stall_hold <= $urandom_range(0, 2);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a stretch with no handshake on either channel means a hang.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no handshake for %0d cycles, %0d results outstanding",
                       WATCHDOG_LIMIT, pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request sender
    // ------------------------------------------------------------------
    int burst_left = 0;
    int len_guess  = 0;        // steering only; the checker owns the real prediction
    int cmd_sent [4];
    int full_hits  = 0;
    int drain_hits = 0;

    // Present one request and hold it until accepted. Returns at the accepting
    // edge. Gaps only open at the start of a new burst, so valid never drops
    // and rises in the same step.
    task automatic issue(input cmd_t c, input logic signed [ITEM_W-1:0] v,
                         input logic [POS_W-1:0] p);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid    <= 1'b1;
        req_cmd      <= c;
        req_value    <= v;
        req_position <= p;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);

        cmd_sent[c]++;
        case (c)
            CMD_INSERT_FRONT:
            begin
                if (len_guess < CAPACITY)
                    len_guess++;
                else
                    full_hits++;
            end
            CMD_DELETE_POS:
            begin
                if (len_guess != 0 && p != 0 && p <= len_guess)
                begin
                    len_guess--;
                    if (len_guess == 0)
                        drain_hits++;
                end
            end
            default:
            begin
                if (len_guess != 0)
                begin
                    len_guess--;
                    if (len_guess == 0)
                        drain_hits++;
                end
            end
        endcase
    endtask

    initial
    begin : stimulus
        int                       random_sent;
        int                       mode;
        int                       run;
        int                       grow_pct;
        int                       roll;
        cmd_t                     c;
        logic signed [ITEM_W-1:0] v;
        logic [POS_W-1:0]         p;

        random_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // every delete on an empty list, position delete included
        issue(CMD_DELETE_FRONT, $urandom, POS_W'($urandom_range(0, 16)));
        issue(CMD_DELETE_BACK, $urandom, POS_W'($urandom_range(0, 16)));
        issue(CMD_DELETE_POS, $urandom, 5'd0);
        issue(CMD_DELETE_POS, $urandom, 5'd16);
        // value extremes
        issue(CMD_INSERT_FRONT, 32'sh7FFF_FFFF, 5'd31);
        issue(CMD_INSERT_FRONT, 32'sh8000_0000, 5'd0);
        issue(CMD_INSERT_FRONT, -32'sd1, 5'd16);
        issue(CMD_INSERT_FRONT, 32'sd0, 5'd1);
        // position zero and position past the end are refused
        issue(CMD_DELETE_POS, $urandom, 5'd0);
        issue(CMD_DELETE_POS, $urandom, 5'd5);
        // position one acts as front, position equal to length as back
        issue(CMD_DELETE_POS, $urandom, 5'd1);
        issue(CMD_DELETE_POS, $urandom, 5'd3);
        issue(CMD_DELETE_FRONT, $urandom, 5'd31);
        issue(CMD_DELETE_BACK, $urandom, 5'd0);
        // fill to capacity, then one insert too many
        for (int i = 0; i <= CAPACITY; i++)
        begin
            issue(CMD_INSERT_FRONT, $urandom, POS_W'($urandom_range(0, 31)));
        end
        // longest walk, a middle walk, then the head
        issue(CMD_DELETE_POS, $urandom, 5'd16);
        issue(CMD_DELETE_POS, $urandom, 5'd8);
        issue(CMD_DELETE_POS, $urandom, 5'd1);

        // --- random part ---
        // Runs of grow, shrink or mixed traffic so the list keeps swinging
        // between empty and full; most position deletes hit a live element.
        while (random_sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 2);
            run  = $urandom_range(8, 60);
            grow_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 45;
            repeat (run)
            begin
                roll = $urandom_range(0, 99);
                if (roll < grow_pct)
                    c = CMD_INSERT_FRONT;
                else
                begin
                    roll = $urandom_range(0, 3);
                    c = (roll == 0) ? CMD_DELETE_FRONT :
                        (roll == 1) ? CMD_DELETE_BACK : CMD_DELETE_POS;
                end

                case ($urandom_range(0, 9))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = $signed(ITEM_W'($urandom_range(0, 4))) - 2;
                    default: v = $urandom;
                endcase

                roll = $urandom_range(0, 99);
                if (c == CMD_DELETE_POS && len_guess > 0 && roll < 80)
                    p = POS_W'($urandom_range(1, len_guess));
                else if (c == CMD_DELETE_POS && roll < 88)
                    p = 5'd0;
                else
                    p = POS_W'($urandom_range(0, 16));

                issue(c, v, p);
                random_sent++;
            end
        end
        req_valid <= 1'b0;

        // let every outstanding result arrive, then watch for strays
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d insert, %0d front, %0d back, %0d by position",
                 cmd_sent[0] + cmd_sent[1] + cmd_sent[2] + cmd_sent[3],
                 cmd_sent[0], cmd_sent[1], cmd_sent[2], cmd_sent[3]);
        $display("%0d results checked; inserts into a full list %0d, drains to empty %0d",
                 results_checked, full_hits, drain_hits);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/blpd_pkg.sv
rtl/core/blpd_channels.sv
rtl/core/blpd_ram.sv
rtl/core/blpd_ctrl.sv
rtl/core/bounded_list_with_position_delete.sv
rtl/core/blpd_checker.sv
bench/list_checker.sv
bench/testbench.sv
